// ----- rtl/greedy_distinct_slot_assignment_unit_defines.svh -----
// Assertion helpers for the file that checks internal behavior.
// Both expect signals named clk and rst_n in the enclosing scope.
`ifndef GREEDY_DISTINCT_SLOT_ASSIGNMENT_UNIT_DEFINES_SVH
`define GREEDY_DISTINCT_SLOT_ASSIGNMENT_UNIT_DEFINES_SVH

// Same-cycle implication
`define GDSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define GDSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gdsa_pkg.sv -----
`default_nettype none
package gdsa_pkg;

  // Sizing
  localparam int MAX_GROUPS    = 128;
  localparam int MAX_RESOURCES = 64;
  localparam int GIDX_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int RIDX_W = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int GCNT_W = $clog2(MAX_GROUPS + 1);
  localparam int RCNT_W = $clog2(MAX_RESOURCES + 1);
  localparam int CNT_W  = (GCNT_W > RCNT_W) ? GCNT_W : RCNT_W;

  // Request and result field widths
  localparam int CMD_W  = 2;
  localparam int IDX_W  = 7;
  localparam int VAL_W  = 8;
  localparam int GC_W   = 8;
  localparam int RC_W   = 7;
  localparam int MASK_W = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_DEM = 2'd0,
    CMD_LOAD_CAP = 2'd1,
    CMD_RUN      = 2'd2,
    CMD_READ     = 2'd3
  } cmd_e;

  // Microprogram addresses
  typedef enum logic [3:0] {
    U_FETCH,
    U_RD_OUT,
    U_GSTART,
    U_GSCAN,
    U_GPICK,
    U_RSTART,
    U_RSCAN,
    U_RTAKE,
    U_RNEXT,
    U_GWRITE,
    U_RUN_DONE
  } step_e;

  typedef enum logic [2:0] {
    JM_NEXT,      // step + 1
    JM_GOTO,      // target
    JM_IF,        // cond ? target : step + 1
    JM_WHILE,     // cond ? same step : target
    JM_DISPATCH   // branch on accepted command
  } jmode_e;

  typedef enum logic [2:0] {
    C_NONE,
    C_SCAN_MORE,
    C_OUT_BUSY,
    C_BEST_ZERO,
    C_DEM_ZERO,
    C_PASS_END
  } cond_e;

  typedef enum logic [1:0] {
    SC_NONE,
    SC_GRP,
    SC_RES
  } scan_e;

  typedef struct packed {
    logic   rdy;       // take a request
    scan_e  scan;      // issue store reads for a max search
    logic   clr_scan;  // restart the search
    logic   pick;      // commit best group
    logic   take;      // commit best resource or flag failure
    logic   gwrite;    // write back group mask
    logic   emit_rd;   // read result
    logic   emit_run;  // run result
    jmode_e jm;
    cond_e  cnd;
    step_e  tgt;
  } ucode_t;

  typedef struct packed {
    logic scan_more;
    logic out_busy;
    logic best_zero;
    logic dem_zero;
    logic pass_end;
    logic acc_run;
    logic acc_read;
  } stat_t;

  // Control store
  function automatic ucode_t ucode_rom(step_e s);
    ucode_t w;
    w = '{rdy: 1'b0, scan: SC_NONE, clr_scan: 1'b0, pick: 1'b0, take: 1'b0,
          gwrite: 1'b0, emit_rd: 1'b0, emit_run: 1'b0, jm: JM_GOTO,
          cnd: C_NONE, tgt: U_FETCH};
    case (s)
      U_FETCH: begin
        w.rdy = 1'b1;
        w.jm  = JM_DISPATCH;
      end
      U_RD_OUT: begin
        w.emit_rd = 1'b1;
        w.jm = JM_WHILE; w.cnd = C_OUT_BUSY; w.tgt = U_FETCH;
      end
      U_GSTART: begin
        w.clr_scan = 1'b1;
        w.jm = JM_IF; w.cnd = C_PASS_END; w.tgt = U_RUN_DONE;
      end
      U_GSCAN: begin
        w.scan = SC_GRP;
        w.jm = JM_WHILE; w.cnd = C_SCAN_MORE; w.tgt = U_GPICK;
      end
      U_GPICK: begin
        w.pick = 1'b1;
        w.jm = JM_IF; w.cnd = C_BEST_ZERO; w.tgt = U_RUN_DONE;
      end
      U_RSTART: begin
        w.clr_scan = 1'b1;
        w.jm = JM_IF; w.cnd = C_DEM_ZERO; w.tgt = U_GWRITE;
      end
      U_RSCAN: begin
        w.scan = SC_RES;
        w.jm = JM_WHILE; w.cnd = C_SCAN_MORE; w.tgt = U_RTAKE;
      end
      U_RTAKE: begin
        w.take = 1'b1;
        w.jm = JM_IF; w.cnd = C_BEST_ZERO; w.tgt = U_GWRITE;
      end
      U_RNEXT: begin
        w.jm = JM_GOTO; w.tgt = U_RSTART;
      end
      U_GWRITE: begin
        w.gwrite = 1'b1;
        w.jm = JM_GOTO; w.tgt = U_GSTART;
      end
      U_RUN_DONE: begin
        w.emit_run = 1'b1;
        w.jm = JM_WHILE; w.cnd = C_OUT_BUSY; w.tgt = U_FETCH;
      end
      default: begin
        w.jm = JM_GOTO; w.tgt = U_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/gdsa_in_if.sv -----
`default_nettype none
interface gdsa_in_if;
  logic                         valid;
  logic                         ready;
  logic [gdsa_pkg::CMD_W-1:0]   cmd;
  logic [gdsa_pkg::IDX_W-1:0]   index;
  logic [gdsa_pkg::VAL_W-1:0]   value;
  logic [gdsa_pkg::GC_W-1:0]    group_count;
  logic [gdsa_pkg::RC_W-1:0]    resource_count;

  modport source (output valid, cmd, index, value, group_count, resource_count,
                  input ready);
  modport sink   (input valid, cmd, index, value, group_count, resource_count,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/gdsa_out_if.sv -----
`default_nettype none
interface gdsa_out_if;
  logic                         valid;
  logic                         ready;
  logic                         feasible;
  logic [gdsa_pkg::MASK_W-1:0]  resource_mask;
  logic                         is_read;

  modport source (output valid, feasible, resource_mask, is_read, input ready);
  modport sink   (input valid, feasible, resource_mask, is_read, output ready);
endinterface
`default_nettype wire

// ----- rtl/gdsa_seq.sv -----
`default_nettype none
module gdsa_seq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  gdsa_pkg::stat_t       status,
  output gdsa_pkg::ucode_t      ctrl,
  output gdsa_pkg::step_e       upc
);
  import gdsa_pkg::*;

  step_e upc_r, upc_nxt;
  logic  cond;

  // Control word for the current step
  assign ctrl = ucode_rom(upc_r);
  assign upc  = upc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_FETCH;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // Condition select and next step
  always_comb begin
    case (ctrl.cnd)
      C_SCAN_MORE: cond = status.scan_more;
      C_OUT_BUSY:  cond = status.out_busy;
      C_BEST_ZERO: cond = status.best_zero;
      C_DEM_ZERO:  cond = status.dem_zero;
      C_PASS_END:  cond = status.pass_end;
      default:     cond = 1'b0;
    endcase

    case (ctrl.jm)
      JM_NEXT:  upc_nxt = step_e'(upc_r + 4'd1);
      JM_GOTO:  upc_nxt = ctrl.tgt;
      JM_IF:    upc_nxt = cond ? ctrl.tgt : step_e'(upc_r + 4'd1);
      JM_WHILE: upc_nxt = cond ? upc_r : ctrl.tgt;
      JM_DISPATCH: begin
        if (status.acc_run) begin
          upc_nxt = U_GSTART;
        end else if (status.acc_read) begin
          upc_nxt = U_RD_OUT;
        end else begin
          upc_nxt = U_FETCH;
        end
      end
      default:  upc_nxt = U_FETCH;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/gdsa_dpath.sv -----
`default_nettype none
module gdsa_dpath (
  input  wire logic        clk,
  input  wire logic        rst_n,
  gdsa_in_if.sink          in_ch,
  gdsa_out_if.source       out_ch,
  input  gdsa_pkg::ucode_t ctrl,
  output gdsa_pkg::stat_t  status
);
  import gdsa_pkg::*;

  // Stores
  logic [VAL_W-1:0]         dem_mem [MAX_GROUPS];
  logic [VAL_W-1:0]         cap_mem [MAX_RESOURCES];
  logic [MAX_RESOURCES-1:0] asg_mem [MAX_GROUPS];

  logic [VAL_W-1:0]         dem_rd_r;
  logic [VAL_W-1:0]         cap_rd_r;
  logic [MAX_RESOURCES-1:0] asg_rd_r;

  logic [MAX_GROUPS-1:0]    served_r;
  logic                     ok_r;

  // Run registers
  logic [GCNT_W-1:0]        ng_r;
  logic [RCNT_W-1:0]        nr_r;
  logic [GCNT_W-1:0]        pass_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     pend_r;
  logic                     pend_res_r;
  logic [GIDX_W-1:0]        pend_idx_r;
  logic [VAL_W-1:0]         best_val_r;
  logic [GIDX_W-1:0]        best_idx_r;
  logic [GIDX_W-1:0]        gsel_r;
  logic [VAL_W-1:0]         dem_r;
  logic [MAX_RESOURCES-1:0] used_r;
  logic                     rd_hit_r;

  // Result register
  logic                     out_valid_r;
  logic                     out_feas_r;
  logic [MASK_W-1:0]        out_mask_r;
  logic                     out_isrd_r;

  logic                     in_acc;
  logic                     g_in_range;
  logic                     r_in_range;
  logic [CNT_W-1:0]         scan_lim;
  logic                     scan_more;
  logic                     issue;
  logic                     out_busy;
  logic                     best_zero;
  logic [VAL_W-1:0]         cand_val;
  logic                     cand_ok;
  logic                     cap_we;
  logic [RIDX_W-1:0]        cap_wa;
  logic [VAL_W-1:0]         cap_wd;

  assign in_ch.ready = ctrl.rdy;
  assign in_acc      = in_ch.valid && ctrl.rdy;
  assign g_in_range  = 32'(in_ch.index) < MAX_GROUPS;
  assign r_in_range  = 32'(in_ch.index) < MAX_RESOURCES;

  // Search limits and status
  assign scan_lim  = (ctrl.scan == SC_RES) ? CNT_W'(nr_r) : CNT_W'(ng_r);
  assign scan_more = cnt_r < scan_lim;
  assign issue     = (ctrl.scan != SC_NONE) && scan_more;
  assign out_busy  = out_valid_r && !out_ch.ready;
  assign best_zero = best_val_r == '0;

  assign status.scan_more = scan_more;
  assign status.out_busy  = out_busy;
  assign status.best_zero = best_zero;
  assign status.dem_zero  = dem_r == '0;
  assign status.pass_end  = pass_r == ng_r;
  assign status.acc_run   = in_acc && (in_ch.cmd == CMD_RUN);
  assign status.acc_read  = in_acc && (in_ch.cmd == CMD_READ);

  // Candidate from the read issued last cycle; strict > keeps the lowest index
  assign cand_val = pend_res_r ? cap_rd_r : dem_rd_r;
  assign cand_ok  = pend_res_r ? !used_r[RIDX_W'(pend_idx_r)] : !served_r[pend_idx_r];

  // Capacity write port: load or decrement
  always_comb begin
    cap_we = 1'b0;
    cap_wa = RIDX_W'(in_ch.index);
    cap_wd = in_ch.value;
    if (in_acc && (in_ch.cmd == CMD_LOAD_CAP) && r_in_range) begin
      cap_we = 1'b1;
    end else if (ctrl.take && !best_zero) begin
      cap_we = 1'b1;
      cap_wa = RIDX_W'(best_idx_r);
      cap_wd = best_val_r - 1'b1;
    end
  end

  // Demand store
  always_ff @(posedge clk) begin
    if (in_acc && (in_ch.cmd == CMD_LOAD_DEM) && g_in_range) begin
      dem_mem[GIDX_W'(in_ch.index)] <= in_ch.value;
    end
    dem_rd_r <= dem_mem[GIDX_W'(cnt_r)];
  end

  // Capacity store
  always_ff @(posedge clk) begin
    if (cap_we) begin
      cap_mem[cap_wa] <= cap_wd;
    end
    cap_rd_r <= cap_mem[RIDX_W'(cnt_r)];
  end

  // Assignment mask store
  always_ff @(posedge clk) begin
    if (ctrl.gwrite) begin
      asg_mem[gsel_r] <= used_r;
    end
    if (in_acc) begin
      asg_rd_r <= asg_mem[GIDX_W'(in_ch.index)];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      served_r <= '0;
      ok_r     <= 1'b1;
      pend_r   <= 1'b0;
    end else begin
      pend_r <= issue;
      if (status.acc_run) begin
        served_r <= '0;
        ok_r     <= 1'b1;
      end else if (ctrl.pick && !best_zero) begin
        served_r[best_idx_r] <= 1'b1;
      end
      if (ctrl.take && best_zero) begin
        ok_r <= 1'b0;
      end
    end
  end

  // Search and allocation registers
  always_ff @(posedge clk) begin
    pend_res_r <= ctrl.scan == SC_RES;
    pend_idx_r <= GIDX_W'(cnt_r);

    if (status.acc_run) begin
      ng_r   <= (32'(in_ch.group_count) > MAX_GROUPS) ?
                GCNT_W'(MAX_GROUPS) : GCNT_W'(in_ch.group_count);
      nr_r   <= (32'(in_ch.resource_count) > MAX_RESOURCES) ?
                RCNT_W'(MAX_RESOURCES) : RCNT_W'(in_ch.resource_count);
      pass_r <= '0;
    end
    if (status.acc_read) begin
      rd_hit_r <= g_in_range && served_r[GIDX_W'(in_ch.index)];
    end

    if (ctrl.clr_scan) begin
      cnt_r      <= '0;
      best_val_r <= '0;
      best_idx_r <= '0;
    end else begin
      if (issue) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (pend_r && cand_ok && (cand_val > best_val_r)) begin
        best_val_r <= cand_val;
        best_idx_r <= pend_idx_r;
      end
    end

    // Start serving the chosen group
    if (ctrl.pick && !best_zero) begin
      gsel_r <= best_idx_r;
      dem_r  <= best_val_r;
      used_r <= '0;
      pass_r <= pass_r + 1'b1;
    end

    // One unit placed
    if (ctrl.take && !best_zero) begin
      used_r[RIDX_W'(best_idx_r)] <= 1'b1;
      dem_r <= dem_r - 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((ctrl.emit_rd || ctrl.emit_run) && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctrl.emit_rd || ctrl.emit_run) && !out_busy) begin
      out_feas_r <= ok_r;
      out_isrd_r <= ctrl.emit_rd;
      out_mask_r <= (ctrl.emit_rd && rd_hit_r) ? MASK_W'(asg_rd_r) : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.feasible      = out_feas_r;
  assign out_ch.resource_mask = out_mask_r;
  assign out_ch.is_read       = out_isrd_r;

endmodule
`default_nettype wire

// ----- rtl/greedy_distinct_slot_assignment_unit.sv -----
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    cmd, index, value, group_count, resource_count
// out_ch    out  valid/ready    feasible, resource_mask, is_read
//
// A load writes its store from the request; a read's result waits on out_ch. A run
// repeats passes: a group search and pick, then per unit of demand a resource
// search and take, then a mask write-back; it ends after the last pass or once no
// demand is left. A search reads one entry a cycle.
// Reset (rst_n, synchronous) returns the sequencer to fetch and sets ok;
// stores hold no reset value. A held result stalls only the emit step.
`default_nettype none
`include "greedy_distinct_slot_assignment_unit_defines.svh"
module greedy_distinct_slot_assignment_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gdsa_in_if.sink    in_ch,
  gdsa_out_if.source out_ch
);
  import gdsa_pkg::*;

  ucode_t ctrl;
  stat_t  status;
  step_e  upc;

  gdsa_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl),
    .upc    (upc)
  );

  gdsa_dpath u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .ctrl   (ctrl),
    .status (status)
  );

  // Requests are taken only at the fetch step
  `GDSA_ASSERT_IMP(a_rdy_fetch, in_ch.ready, upc == U_FETCH, "ready outside fetch")
  // A result appears only out of an emit step
  `GDSA_ASSERT_IMP(a_out_src, $rose(out_ch.valid),
    ($past(upc) == U_RD_OUT) || ($past(upc) == U_RUN_DONE), "result without emit")
  // A run request starts the group search next
  `GDSA_ASSERT_NXT(a_run_go, in_ch.valid && in_ch.ready && (in_ch.cmd == CMD_RUN),
    upc == U_GSTART, "run not started")

endmodule
`default_nettype wire
